// File: hdl/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

  // item kinds
  localparam logic [1:0] KIND_AVAIL = 2'd0;
  localparam logic [1:0] KIND_MAX   = 2'd1;
  localparam logic [1:0] KIND_ALLOC = 2'd2;
  localparam logic [1:0] KIND_REQ   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_AVAIL  = 2'd1;
  localparam logic [1:0] ST_NEED   = 2'd2;
  localparam logic [1:0] ST_UNSAFE = 2'd3;

  // number of amount ports
  localparam int AMT_PORTS = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_START,
    S_WALK,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_LD_MAX,
    CELL_LD_ALLOC,
    CELL_ADD,
    CELL_SUB
  } cell_op_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t op;
    logic     clr;
    logic     run;
  } cell_cmd_t;

endpackage

// File: hdl/bsa_cell.sv
`timescale 1ns / 1ps

module bsa_cell #(
  parameter int NUM_RES    = 3,
  parameter int COUNT_BITS = 8,
  parameter int WORK_BITS  = 12,
  parameter int IDX_BITS   = 3,
  parameter int IDX        = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bsa_pkg::cell_cmd_t                   cmd,
  input  logic [IDX_BITS-1:0]                  sel,
  input  logic [NUM_RES-1:0][COUNT_BITS-1:0]   amt,
  input  logic                                 tok_in,
  input  logic [NUM_RES-1:0][WORK_BITS-1:0]    work_in,
  output logic                                 tok_out,
  output logic [NUM_RES-1:0][WORK_BITS-1:0]    work_out,
  output logic                                 take,
  output logic                                 done,
  output logic [NUM_RES-1:0][COUNT_BITS-1:0]   max_row,
  output logic [NUM_RES-1:0][COUNT_BITS-1:0]   alloc_row
);
  import bsa_pkg::*;

  logic hit;
  logic fit;

  assign hit = (sel == IDX_BITS'(IDX));

  // need (signed) against the passing work vector, all resources at once
  always_comb begin
    logic [COUNT_BITS:0] need;
    fit = 1'b1;
    for (int r = 0; r < NUM_RES; r++) begin
      need = {1'b0, max_row[r]} - {1'b0, alloc_row[r]};
      if (!need[COUNT_BITS] &&
          ({{(WORK_BITS-COUNT_BITS){1'b0}}, need[COUNT_BITS-1:0]} > work_in[r])) begin
        fit = 1'b0;
      end
    end
  end

  assign take = cmd.run && tok_in && !done && fit;

  // token, done mark and row storage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out   <= 1'b0;
      done      <= 1'b0;
      max_row   <= '0;
      alloc_row <= '0;
    end else begin
      tok_out <= tok_in && cmd.run;
      if (cmd.clr) begin
        done <= 1'b0;
      end else if (take) begin
        done <= 1'b1;
      end
      if (hit) begin
        case (cmd.op)
          CELL_LD_MAX:   max_row   <= amt;
          CELL_LD_ALLOC: alloc_row <= amt;
          CELL_ADD: begin
            for (int r = 0; r < NUM_RES; r++) alloc_row[r] <= alloc_row[r] + amt[r];
          end
          CELL_SUB: begin
            for (int r = 0; r < NUM_RES; r++) alloc_row[r] <= alloc_row[r] - amt[r];
          end
          default: ;
        endcase
      end
    end
  end

  // work vector hand-off to the next cell
  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_RES; r++) begin
      if (take) begin
        work_out[r] <= work_in[r] + {{(WORK_BITS-COUNT_BITS){1'b0}}, alloc_row[r]};
      end else begin
        work_out[r] <= work_in[r];
      end
    end
  end

endmodule

// File: hdl/bankers_safety_allocator.sv
`timescale 1ns / 1ps
// loads: the item is checked in S_CHECK and the result registered from S_DONE; rejected
//   requests the same. granted request: S_CHECK, S_START, then the work token walks
//   the ring of process cells in S_WALK until every process is done, then S_DONE
// one item at a time: input is taken again once the result sits in the output register
// reset (rst, synchronous) clears available counts, max and allocation rows, done marks

module bankers_safety_allocator #(
  parameter int NUM_PROCS  = 8,
  parameter int NUM_RES    = 3,
  parameter int COUNT_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [2:0] process,
  input  logic [7:0] amount_0,
  input  logic [7:0] amount_1,
  input  logic [7:0] amount_2,
  input  logic [7:0] amount_3,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       granted,
  output logic [1:0] status
);
  import bsa_pkg::*;

  localparam int WORK_BITS = COUNT_BITS + $clog2(NUM_PROCS + 1);
  localparam int IDX_BITS  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int CNT_BITS  = $clog2(NUM_PROCS + 1);

  typedef logic [NUM_RES-1:0][COUNT_BITS-1:0] row_t;
  typedef logic [NUM_RES-1:0][WORK_BITS-1:0]  work_t;

  state_t state, state_next;

  logic [1:0]          kind_q;
  logic [2:0]          proc_q;
  row_t                amt_q;
  row_t                amt_in;
  row_t                avail, avail_next;
  logic                res_g, res_g_next;
  logic [1:0]          res_s, res_s_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic                first, first_next;

  cell_cmd_t           cmd;
  logic [IDX_BITS-1:0] sel;
  logic                proc_ok;
  logic [15:0]         proc_ext;

  logic [NUM_PROCS-1:0] tok_q;
  logic [NUM_PROCS-1:0] takes;
  logic [NUM_PROCS-1:0] dones;
  work_t                work_q [NUM_PROCS];
  row_t                 max_rows [NUM_PROCS];
  row_t                 alloc_rows [NUM_PROCS];
  logic                 ring_tok;
  work_t                ring_work;
  work_t                avail_ext;

  logic                 chk_fail;
  logic [1:0]           chk_s;
  logic                 out_free;

  // amounts masked or extended to the count width
  always_comb begin
    logic [AMT_PORTS-1:0][15:0] wide;
    wide[0] = {8'b0, amount_0};
    wide[1] = {8'b0, amount_1};
    wide[2] = {8'b0, amount_2};
    wide[3] = {8'b0, amount_3};
    for (int r = 0; r < NUM_RES; r++) amt_in[r] = wide[r][COUNT_BITS-1:0];
  end

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign proc_ext = {13'b0, proc_q};
  assign proc_ok  = (proc_ext < 16'(NUM_PROCS));
  assign sel      = proc_ext[IDX_BITS-1:0];

  // request check on the addressed row, resource 0 first
  always_comb begin
    logic [COUNT_BITS:0] need;
    chk_fail = 1'b0;
    chk_s    = ST_OK;
    for (int r = 0; r < NUM_RES; r++) begin
      need = {1'b0, max_rows[sel][r]} - {1'b0, alloc_rows[sel][r]};
      if (!chk_fail) begin
        if (amt_q[r] > avail[r]) begin
          chk_fail = 1'b1;
          chk_s    = ST_AVAIL;
        end else if (need[COUNT_BITS] || (amt_q[r] > need[COUNT_BITS-1:0])) begin
          chk_fail = 1'b1;
          chk_s    = ST_NEED;
        end
      end
    end
  end

  // ring input: fresh token with the available vector, or the last cell's output
  always_comb begin
    for (int r = 0; r < NUM_RES; r++) begin
      avail_ext[r] = {{(WORK_BITS-COUNT_BITS){1'b0}}, avail[r]};
    end
    ring_tok  = first ? 1'b1 : tok_q[NUM_PROCS-1];
    ring_work = first ? avail_ext : work_q[NUM_PROCS-1];
  end

  // row of process cells
  for (genvar i = 0; i < NUM_PROCS; i++) begin : g_cell
    logic  tin;
    work_t win;
    if (i == 0) begin : g_head
      assign tin = ring_tok;
      assign win = ring_work;
    end else begin : g_body
      assign tin = tok_q[i-1];
      assign win = work_q[i-1];
    end
    bsa_cell #(
      .NUM_RES   (NUM_RES),
      .COUNT_BITS(COUNT_BITS),
      .WORK_BITS (WORK_BITS),
      .IDX_BITS  (IDX_BITS),
      .IDX       (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (sel),
      .amt      (amt_q),
      .tok_in   (tin),
      .work_in  (win),
      .tok_out  (tok_q[i]),
      .work_out (work_q[i]),
      .take     (takes[i]),
      .done     (dones[i]),
      .max_row  (max_rows[i]),
      .alloc_row(alloc_rows[i])
    );
  end

  // next state and controls
  always_comb begin
    state_next = state;
    avail_next = avail;
    res_g_next = res_g;
    res_s_next = res_s;
    cnt_next   = cnt;
    first_next = first;
    cmd        = '{op: CELL_NOP, clr: 1'b0, run: 1'b0};
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_DONE;
        res_g_next = 1'b1;
        res_s_next = ST_OK;
        case (kind_q)
          KIND_AVAIL: avail_next = amt_q;
          KIND_MAX, KIND_ALLOC: begin
            if (proc_ok) begin
              cmd.op = (kind_q == KIND_MAX) ? CELL_LD_MAX : CELL_LD_ALLOC;
            end else begin
              res_g_next = 1'b0;
            end
          end
          KIND_REQ: begin
            if (!proc_ok) begin
              res_g_next = 1'b0;
              res_s_next = ST_NEED;
            end else if (chk_fail) begin
              res_g_next = 1'b0;
              res_s_next = chk_s;
            end else begin
              cmd.op     = CELL_ADD;
              state_next = S_START;
              for (int r = 0; r < NUM_RES; r++) avail_next[r] = avail[r] - amt_q[r];
            end
          end
          default: ;
        endcase
      end
      S_START: begin
        cmd.clr    = 1'b1;
        cnt_next   = '0;
        first_next = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.run    = 1'b1;
        first_next = 1'b0;
        if (&dones) begin
          res_g_next = 1'b1;
          res_s_next = ST_OK;
          state_next = S_DONE;
        end else if (!(|takes) && (cnt == CNT_BITS'(NUM_PROCS - 1))) begin
          // no progress over a full lap: roll the request back
          cmd.op     = CELL_SUB;
          res_g_next = 1'b0;
          res_s_next = ST_UNSAFE;
          state_next = S_DONE;
          for (int r = 0; r < NUM_RES; r++) avail_next[r] = avail[r] + amt_q[r];
        end else begin
          cnt_next = (|takes) ? '0 : cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      avail     <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      first     <= 1'b0;
    end else begin
      avail <= avail_next;
      cnt   <= cnt_next;
      first <= first_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item capture and result payload
  always_ff @(posedge clk) begin
    res_g <= res_g_next;
    res_s <= res_s_next;
    if (state == S_IDLE && in_valid) begin
      kind_q <= kind;
      proc_q <= process;
      amt_q  <= amt_in;
    end
    if (state == S_DONE && out_free) begin
      granted <= res_g;
      status  <= res_s;
    end
  end

endmodule

// File: hdl/bsa_checker.sv
`timescale 1ns / 1ps

module bsa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       granted,
  input logic [1:0] status
);
  import bsa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(granted) && $stable(status))
    else $error("stalled result changed");

  // a grant always carries the ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> status == ST_OK)
    else $error("grant with non-ok status");

  // one item at a time: a transfer in closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // no result can appear in the cycle right after an input transfer
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind bankers_safety_allocator bsa_checker u_bsa_checker (.*);
